// File: src/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
`timescale 1ns / 1ps
package swm_pkg;
   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int DATA_W     = 32;
   localparam int WIN_W      = 7;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         age;
   } entry_type;

   // Link handed from a cell to its right-hand neighbor.
   typedef struct packed {
      entry_type b;     // entry left at this slot after eviction
      logic      le;    // that entry is valid and <= the new sample
      logic      gone;  // eviction happened at this slot or to its left
   } link_type;

   // Broadcast control to every cell.
   typedef struct packed {
      logic                     step;
      logic signed [DATA_W-1:0] sample;
      logic [CNT_W-1:0]         fill;
      logic [CNT_W-1:0]         kept;    // entries left after eviction
      logic                     evict;
      logic [IDX_W-1:0]         oldest;  // age of the entry to evict
   } ctrl_type;
endpackage

// File: src/swm_cell.sv
// One slot of the sorted window: eviction shift-left and insertion shift-right.
`timescale 1ns / 1ps
module swm_cell (
   input  logic                clock,
   input  logic [swm_pkg::IDX_W-1:0] idx,
   input  swm_pkg::ctrl_type   ctrl,
   input  swm_pkg::link_type   link_prev,
   input  swm_pkg::entry_type  next_entry,
   output swm_pkg::link_type   link_next,
   output swm_pkg::entry_type  entry
);
   swm_pkg::entry_type entry_ff;
   swm_pkg::entry_type entry_in;
   logic               here_valid;
   logic               evict_here;
   logic               b_valid;

   assign here_valid = {1'b0, idx} < ctrl.fill;
   assign evict_here = ctrl.evict && here_valid && (entry_ff.age == ctrl.oldest);
   assign b_valid    = {1'b0, idx} < ctrl.kept;

   always_comb begin
      link_next.gone = link_prev.gone | evict_here;
      link_next.b    = link_next.gone ? next_entry : entry_ff;
      link_next.le   = b_valid && (link_next.b.value <= ctrl.sample);
   end

   always_comb begin
      if (link_next.le) begin
         entry_in.value = link_next.b.value;
         entry_in.age   = link_next.b.age + 1'b1;
      end else if (link_prev.le) begin
         entry_in.value = ctrl.sample;
         entry_in.age   = '0;
      end else begin
         entry_in.value = link_prev.b.value;
         entry_in.age   = link_prev.b.age + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
endmodule

// File: src/sliding_window_median.sv
// Top level of the sliding window median filter.
// Takes one signed 32-bit sample per cycle into a chain of sorted cells; once
// the window is full, each sample evicts the oldest entry and is inserted at
// its sorted place in the same cycle. Once window_size samples are held, each
// sample yields the lower median, read from the cells into the output register;
// that register holds it while rsp_ready is low, and the input stalls only when a
// second result waits behind it. Writing csr_window_size (0 acts as 1, above 64 as
// 64) empties the window; write it only while the block is idle.
`timescale 1ns / 1ps
module sliding_window_median (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [swm_pkg::DATA_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [swm_pkg::DATA_W-1:0] rsp_median,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swm_pkg::WIN_W-1:0]         csr_window_size
);
   logic [swm_pkg::WIN_W-1:0]         win_ff;
   logic [swm_pkg::CNT_W-1:0]         fill_ff, fill_in;
   logic                              pend_ff, pend_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [swm_pkg::DATA_W-1:0] median_ff, median_in;

   logic [swm_pkg::CNT_W-1:0] weff;
   logic [swm_pkg::IDX_W-1:0] win_m1;
   logic [swm_pkg::IDX_W-1:0] rank_idx;
   logic                      step, cfg_wr, evict_on, full_after, stage_free;
   logic signed [swm_pkg::DATA_W-1:0] sel_value;

   swm_pkg::ctrl_type  ctrl;
   swm_pkg::link_type  link [0:swm_pkg::MAX_WINDOW];
   swm_pkg::entry_type ent  [0:swm_pkg::MAX_WINDOW-1];

   always_comb begin
      if (win_ff == '0) begin
         weff = swm_pkg::CNT_W'(1);
      end else if (int'(win_ff) > swm_pkg::MAX_WINDOW) begin
         weff = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
      end else begin
         weff = swm_pkg::CNT_W'(win_ff);
      end
   end

   assign win_m1   = swm_pkg::IDX_W'(weff - 1'b1);
   assign rank_idx = win_m1 >> 1;

   assign stage_free = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !reset && (!pend_ff || stage_free);
   assign csr_ready  = !reset;
   assign step       = req_valid && req_ready;
   assign cfg_wr     = csr_valid && csr_ready;
   assign evict_on   = (fill_ff == weff);
   assign full_after = evict_on || ((fill_ff + 1'b1) == weff);

   always_comb begin
      ctrl.step   = step;
      ctrl.sample = req_sample;
      ctrl.fill   = fill_ff;
      ctrl.kept   = evict_on ? fill_ff - 1'b1 : fill_ff;
      ctrl.evict  = evict_on;
      ctrl.oldest = win_m1;
   end

   always_comb begin
      link[0].b    = '0;
      link[0].le   = 1'b1;
      link[0].gone = 1'b0;
   end

   for (genvar g = 0; g < swm_pkg::MAX_WINDOW; g++) begin : g_cell
      swm_pkg::entry_type nxt;
      if (g == swm_pkg::MAX_WINDOW - 1) begin : g_last
         assign nxt = ent[g];
      end else begin : g_mid
         assign nxt = ent[g+1];
      end
      swm_cell u_cell (
         .clock      (clock),
         .idx        (swm_pkg::IDX_W'(g)),
         .ctrl       (ctrl),
         .link_prev  (link[g]),
         .next_entry (nxt),
         .link_next  (link[g+1]),
         .entry      (ent[g])
      );
   end

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
         if (rank_idx == swm_pkg::IDX_W'(i)) begin
            sel_value = sel_value | ent[i].value;
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cfg_wr) begin
         fill_in = '0;
      end else if (step && !evict_on) begin
         fill_in = fill_ff + 1'b1;
      end
      pend_in      = (step && full_after) || (pend_ff && !stage_free);
      rsp_valid_in = stage_free ? pend_ff : rsp_valid_ff;
      median_in    = (stage_free && pend_ff) ? sel_value : median_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= swm_pkg::WIN_W'(1);
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            win_ff <= csr_window_size;
         end
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = median_ff;
endmodule

// File: src/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top.
`timescale 1ns / 1ps
module swm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [swm_pkg::DATA_W-1:0] rsp_median,
   input logic                              csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("result word changed before it was taken");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without a matching input word");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the output side is free");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> csr_ready)
      else $error("configuration port not ready");
endmodule

bind sliding_window_median swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_median (rsp_median),
   .csr_ready  (csr_ready)
);

// File: test/sliding_window_median_test.sv
// Self-checking testbench for the sliding window median filter: table, then random phases.
`timescale 1ns / 1ps
module sliding_window_median_test;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 4;
   localparam int RANDOM_ITEMS = 1050;
   localparam int ROW_COUNT    = 28;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [swm_pkg::DATA_W-1:0] data;
      logic                       typed;
      logic [swm_pkg::DATA_W-1:0] median;
   } row_type;

   logic                              clock;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_ready;
   logic signed [swm_pkg::DATA_W-1:0] req_sample      = '0;
   logic                              rsp_valid;
   logic                              rsp_ready       = 1'b0;
   logic signed [swm_pkg::DATA_W-1:0] rsp_median;
   logic                              csr_valid       = 1'b0;
   logic                              csr_ready;
   logic [swm_pkg::WIN_W-1:0]         csr_window_size = '0;

   int                                window_hist[$];   // held samples, oldest first
   logic [swm_pkg::WIN_W-1:0]         window_reg = 7'd1;
   logic signed [swm_pkg::DATA_W-1:0] median_expected[$];
   logic signed [swm_pkg::DATA_W-1:0] median_front;
   int                                mismatch_count = 0;
   bit                                no_gaps = 1'b0;
   bit                                long_hold = 1'b0;
   bit                                hold_done = 1'b0;
   int                                rsp_gap = 0;
   int                                rsp_hold = 0;
   int                                rsp_draw;

   sliding_window_median u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_median      (rsp_median),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int window_len(input logic [swm_pkg::WIN_W-1:0] w);
      if (w == 0) return 1;
      if (w > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
      return int'(w);
   endfunction

   function automatic bit predict_median(input int s, output int m);
      int len;
      int ordered[swm_pkg::MAX_WINDOW];
      int n;
      int k;
      int j;
      int v;
      len = window_len(window_reg);
      while (window_hist.size() >= len) v = window_hist.pop_front();
      window_hist.push_back(s);
      m = 0;
      if (window_hist.size() < len) return 1'b0;
      n = window_hist.size();
      for (k = 0; k < n; k++) begin
         v = window_hist[k];
         j = k;
         while (j > 0 && ordered[j-1] > v) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = v;
      end
      m = ordered[(len + 1) / 2 - 1];
      return 1'b1;
   endfunction

   function automatic logic [swm_pkg::DATA_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_sample(input logic [swm_pkg::DATA_W-1:0] s, input bit typed,
                              input logic [swm_pkg::DATA_W-1:0] typed_median);
      int gap;
      int m;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      if (predict_median(s, m)) median_expected.push_back(typed ? typed_median : m);
   endtask

   task automatic write_window(input logic [swm_pkg::WIN_W-1:0] w);
      req_valid <= 1'b0;
      while (median_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      window_reg  = w;
      window_hist.delete();
   endtask

   // result side: random gaps per word, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (long_hold && !hold_done) begin
         hold_done <= 1'b1;
         rsp_hold  <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
      end else if (rsp_valid && rsp_ready) begin
         rsp_draw = no_gaps ? 0 : $urandom_range(0, 17);
         rsp_gap   <= (rsp_draw > 0) ? rsp_draw - 1 : 0;
         rsp_ready <= (rsp_draw == 0);
      end else if (!rsp_ready) begin
         if (rsp_gap > 0) rsp_gap <= rsp_gap - 1;
         else rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (median_expected.size() == 0) begin
            $display("%0t: median word %0d arrived, none expected", $time, rsp_median);
            mismatch_count++;
         end else begin
            median_front = median_expected.pop_front();
            if (rsp_median !== median_front) begin
               $display("%0t: median expected %0d, got %0d", $time, median_front,
                        rsp_median);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      row_type                   rows [0:ROW_COUNT-1];
      logic [swm_pkg::WIN_W-1:0] preset [0:6];
      logic [swm_pkg::WIN_W-1:0] w;
      int                        r;
      int                        k;
      int                        total;
      int                        phase;
      int                        count;
      int                        len;

      // window of one after reset: each sample is its own median
      rows[0]  = '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000};
      rows[1]  = '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF};
      rows[2]  = '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0000};
      rows[3]  = '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF};
      rows[4]  = '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 32'h0000_0001};
      // size zero acts as one
      rows[5]  = '{ROW_CSR,    32'd0,         1'b0, 32'd0};
      rows[6]  = '{ROW_SAMPLE, 32'h5555_5555, 1'b1, 32'h5555_5555};
      rows[7]  = '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA};
      rows[8]  = '{ROW_CSR,    32'd2,         1'b0, 32'd0};
      rows[9]  = '{ROW_SAMPLE, 32'd5,         1'b0, 32'd0};
      rows[10] = '{ROW_SAMPLE, 32'd7,         1'b0, 32'd0};
      rows[11] = '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'd0};
      rows[12] = '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'd0};
      // ties
      rows[13] = '{ROW_CSR,    32'd3,         1'b0, 32'd0};
      rows[14] = '{ROW_SAMPLE, 32'd4,         1'b0, 32'd0};
      rows[15] = '{ROW_SAMPLE, 32'd4,         1'b0, 32'd0};
      rows[16] = '{ROW_SAMPLE, 32'd4,         1'b0, 32'd0};
      rows[17] = '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, 32'd0};
      rows[18] = '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, 32'd0};
      rows[19] = '{ROW_SAMPLE, 32'd9,         1'b0, 32'd0};
      // partly filled window, then cleared by a write
      rows[20] = '{ROW_CSR,    32'd5,         1'b0, 32'd0};
      rows[21] = '{ROW_SAMPLE, 32'd1,         1'b0, 32'd0};
      rows[22] = '{ROW_SAMPLE, 32'd2,         1'b0, 32'd0};
      rows[23] = '{ROW_CSR,    32'd4,         1'b0, 32'd0};
      rows[24] = '{ROW_SAMPLE, 32'd9,         1'b0, 32'd0};
      rows[25] = '{ROW_SAMPLE, 32'd8,         1'b0, 32'd0};
      rows[26] = '{ROW_SAMPLE, 32'd7,         1'b0, 32'd0};
      rows[27] = '{ROW_SAMPLE, 32'd6,         1'b0, 32'd0};

      preset[0] = 7'd64;
      preset[1] = 7'd127;
      preset[2] = 7'd0;
      preset[3] = 7'd1;
      preset[4] = 7'd2;
      preset[5] = 7'd100;
      preset[6] = 7'd33;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < ROW_COUNT; r++) begin
         if (rows[r].kind == ROW_CSR) write_window(rows[r].data[swm_pkg::WIN_W-1:0]);
         else send_sample(rows[r].data, rows[r].typed, rows[r].median);
      end

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         if (phase < 7) w = preset[phase];
         else if ($urandom_range(0, 5) == 0) w = swm_pkg::WIN_W'($urandom_range(0, 127));
         else w = swm_pkg::WIN_W'($urandom_range(1, 12));
         len     = window_len(w);
         no_gaps = ($urandom_range(0, 3) == 0);
         count   = len + $urandom_range(0, 40);
         if ($urandom_range(0, 7) == 0) count = $urandom_range(0, len - 1);
         write_window(w);
         // input backs up behind a long receiver stall
         if (phase == 3) begin
            no_gaps   = 1'b1;
            count     = 60;
            long_hold = 1'b1;
         end
         for (k = 0; k < count; k++) send_sample(random_sample(), 1'b0, '0);
         total += count;
         phase++;
      end

      req_valid <= 1'b0;
      while (median_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
